@@ design/utf8sd_pkg.sv @@
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Shared types and constants of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

  localparam int unsigned CP_W = 21;
  localparam int unsigned CNT_W = 3;

  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [CP_W-1:0] MAX_CP         = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO        = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI        = 21'h00DFFF;
  localparam logic [CP_W-1:0] MIN_CP_2B      = 21'h000080;
  localparam logic [CP_W-1:0] MIN_CP_3B      = 21'h000800;
  localparam logic [CP_W-1:0] MIN_CP_4B      = 21'h010000;

  // Results caused by one byte: every result but the last is a replacement
  // flagged as an error, so only the count and the last result are kept.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CP_W-1:0]  last_cp;
    logic             last_err;
  } desc_t;

endpackage

@@ design/utf8_stream_decoder_top.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// Streaming UTF-8 decoder that replaces malformed input with U+FFFD.
// ----------------------------------------------------------------------------
// Bytes enter an input register, are decoded in one pass against the pending
// sequence state, and land in a result register that hands out the code
// points. One byte is taken per clock cycle when the result register is free.
// A byte that causes k results holds the result register until all k have
// left (k is 0 to 4, at most 4 only on malformed input), and the input
// register lets one more byte in meanwhile.
module utf8_stream_decoder_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_text_byte,
  input  logic                        in_end_of_text,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [utf8sd_pkg::CP_W-1:0] out_code_point,
  output logic                        out_is_error,
  output logic                        out_last_of_run
);

  logic              in_valid_r, in_valid_nxt;
  logic [7:0]        byte_r;
  logic              eot_r;
  logic              free;
  logic              advance;
  utf8sd_pkg::desc_t desc;

  // A byte moves to decode when the result register can take its results.
  assign advance  = in_valid_r && free;
  assign in_ready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  // Input register for one transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_text_byte;
      eot_r  <= in_end_of_text;
    end
  end

  utf8sd_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .text_byte   (byte_r),
    .end_of_text (eot_r),
    .advance     (advance),
    .desc        (desc)
  );

  utf8sd_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (advance),
    .desc            (desc),
    .free            (free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_code_point  (out_code_point),
    .out_is_error    (out_is_error),
    .out_last_of_run (out_last_of_run)
  );

endmodule

@@ design/utf8sd_decode.sv @@
// ----------------------------------------------------------------------------
// utf8sd_decode
// Sequence state and single-pass decode of one byte into a result descriptor.
// ----------------------------------------------------------------------------
module utf8sd_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          text_byte,
  input  logic                end_of_text,
  input  logic                advance,
  output utf8sd_pkg::desc_t   desc
);

  typedef struct packed {
    logic                        has_result;
    logic [utf8sd_pkg::CP_W-1:0] cp;
    logic                        err;
    logic                        start;
    logic [1:0]                  len;
    logic [utf8sd_pkg::CP_W-1:0] pay;
  } fresh_t;

  logic [utf8sd_pkg::CP_W-1:0] pay_r, pay_nxt;
  logic [1:0]                  len_r, len_nxt;
  logic [1:0]                  cs_r, cs_nxt;

  // Decode of a byte with nothing pending.
  function automatic fresh_t fresh_decode(input logic [7:0] b, input logic eot);
    fresh_t f;
    f.has_result = 1'b0;
    f.cp         = utf8sd_pkg::REPLACEMENT_CP;
    f.err        = 1'b1;
    f.start      = 1'b0;
    f.len        = 2'd0;
    f.pay        = '0;
    if (b[7] == 1'b0) begin
      f.has_result = 1'b1;
      f.cp         = {13'd0, b};
      f.err        = 1'b0;
    end else if (b[7:5] == 3'b110) begin
      f.start = 1'b1;
      f.len   = 2'd1;
      f.pay   = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      f.start = 1'b1;
      f.len   = 2'd2;
      f.pay   = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      f.start = 1'b1;
      f.len   = 2'd3;
      f.pay   = {18'd0, b[2:0]};
    end else begin
      f.has_result = 1'b1;
    end
    // A lead byte at end of text is an unfinished sequence.
    if (f.start && eot) begin
      f.has_result = 1'b1;
      f.start      = 1'b0;
      f.len        = 2'd0;
      f.pay        = '0;
    end
    return f;
  endfunction

  fresh_t                      fr;
  logic [utf8sd_pkg::CP_W-1:0] ext_pay;
  logic [2:0]                  ext_cs;
  logic [utf8sd_pkg::CP_W-1:0] lowest;
  logic                        bad_value;

  // Next state and result descriptor for the byte in the input register.
  always_comb begin
    fr        = fresh_decode(text_byte, end_of_text);
    ext_pay   = {pay_r[14:0], text_byte[5:0]};
    ext_cs    = {1'b0, cs_r} + 3'd1;
    case (len_r)
      2'd1:    lowest = utf8sd_pkg::MIN_CP_2B;
      2'd2:    lowest = utf8sd_pkg::MIN_CP_3B;
      default: lowest = utf8sd_pkg::MIN_CP_4B;
    endcase
    bad_value = (ext_pay < lowest) || (ext_pay > utf8sd_pkg::MAX_CP) ||
                ((ext_pay >= utf8sd_pkg::SURR_LO) && (ext_pay <= utf8sd_pkg::SURR_HI));

    desc.count    = '0;
    desc.last_cp  = utf8sd_pkg::REPLACEMENT_CP;
    desc.last_err = 1'b1;
    pay_nxt       = '0;
    len_nxt       = 2'd0;
    cs_nxt        = 2'd0;

    if (len_r == 2'd0) begin
      desc.count    = {2'd0, fr.has_result};
      desc.last_cp  = fr.cp;
      desc.last_err = fr.err;
      len_nxt       = fr.len;
      pay_nxt       = fr.pay;
    end else if (text_byte[7:6] != 2'b10) begin
      // Broken sequence: lead plus seen continuations, then a fresh decode.
      desc.count = {1'b0, cs_r} + 3'd1 + {2'd0, fr.has_result};
      if (fr.has_result) begin
        desc.last_cp  = fr.cp;
        desc.last_err = fr.err;
      end
      len_nxt = fr.len;
      pay_nxt = fr.pay;
    end else if (ext_cs >= {1'b0, len_r}) begin
      // Sequence complete.
      if (bad_value) begin
        desc.count = {1'b0, len_r} + 3'd1;
      end else begin
        desc.count    = 3'd1;
        desc.last_cp  = ext_pay;
        desc.last_err = 1'b0;
      end
    end else if (end_of_text) begin
      desc.count = 3'd1;
    end else begin
      len_nxt = len_r;
      pay_nxt = ext_pay;
      cs_nxt  = ext_cs[1:0];
    end

    if (end_of_text) begin
      len_nxt = 2'd0;
      pay_nxt = '0;
      cs_nxt  = 2'd0;
    end
  end

  // Sequence state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pay_r <= '0;
      len_r <= 2'd0;
      cs_r  <= 2'd0;
    end else if (advance) begin
      pay_r <= pay_nxt;
      len_r <= len_nxt;
      cs_r  <= cs_nxt;
    end
  end

  a_cs_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r == 2'd0) ? (cs_r == 2'd0) : (cs_r < len_r))
    else $error("continuation count not below sequence length");

  a_idle_payload_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r == 2'd0) |-> (pay_r == '0))
    else $error("payload not clear with no sequence pending");

  a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && end_of_text) |=> (len_r == 2'd0))
    else $error("sequence still pending after end of text");

endmodule

@@ design/utf8sd_emit.sv @@
// ----------------------------------------------------------------------------
// utf8sd_emit
// Result register that plays out the results of one descriptor in order.
// ----------------------------------------------------------------------------
module utf8sd_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  utf8sd_pkg::desc_t           desc,
  output logic                        free,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [utf8sd_pkg::CP_W-1:0] out_code_point,
  output logic                        out_is_error,
  output logic                        out_last_of_run
);

  logic [utf8sd_pkg::CNT_W-1:0] rem_r, rem_nxt;
  logic [utf8sd_pkg::CP_W-1:0]  last_cp_r;
  logic                         last_err_r;
  logic                         take;

  assign out_valid       = (rem_r != '0);
  assign out_last_of_run = (rem_r == 3'd1);
  assign take            = out_valid && out_ready;
  // The register can take a new descriptor once its final result leaves.
  assign free            = !out_valid || (take && out_last_of_run);

  // Earlier results of a run are always replacements.
  assign out_code_point = out_last_of_run ? last_cp_r : utf8sd_pkg::REPLACEMENT_CP;
  assign out_is_error   = out_last_of_run ? last_err_r : 1'b1;

  always_comb begin
    rem_nxt = rem_r;
    if (load && free) begin
      rem_nxt = desc.count;
    end else if (take) begin
      rem_nxt = rem_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  // Payload of the last result; no reset needed.
  always_ff @(posedge clk) begin
    if (load && free) begin
      last_cp_r  <= desc.last_cp;
      last_err_r <= desc.last_err;
    end
  end

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= 3'd4)
    else $error("more than four results pending");

  a_early_is_replacement: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_of_run) |->
      (out_is_error && (out_code_point == utf8sd_pkg::REPLACEMENT_CP)))
    else $error("non-final result is not a replacement");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !out_last_of_run) |=> out_valid)
    else $error("result run ended early");

endmodule

@@ tb/utf8_stream_decoder_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top_tb
// Self-checking testbench for the streaming UTF-8 decoder.
// ----------------------------------------------------------------------------
// A short table of hand-picked byte sequences goes in first. It covers ASCII,
// stray continuations, invalid lead bytes, overlong forms, surrogates, values
// above U+10FFFF, an encoded U+FFFD and end of text inside a sequence. Random
// text follows: mostly well-formed characters, with overlong, out-of-range,
// surrogate, truncated and noise bytes mixed in. A behavioral decoder predicts
// every code point the table does not fix, and outputs are checked in order.
// Both sides idle at random in phases 1 and 2, and not at all in phase 3.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top_tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned DRAIN_CYCLES = 8;

  // One expected output transaction.
  typedef struct packed {
    logic [utf8sd_pkg::CP_W-1:0] cp;
    logic                        err;
    logic                        last;
  } cp_result_t;

  // One row of the directed table. Rows with fixed_exp set carry their
  // expected results: n_results copies of cp and err.
  typedef struct packed {
    logic [7:0]                  text_byte;
    logic                        eot;
    logic                        fixed_exp;
    logic [2:0]                  n_results;
    logic [utf8sd_pkg::CP_W-1:0] cp;
    logic                        err;
  } vector_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [7:0]                  in_text_byte = 8'h00;
  logic                        in_end_of_text = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [utf8sd_pkg::CP_W-1:0] out_code_point;
  logic                        out_is_error;
  logic                        out_last_of_run;

  // Decoder state as the testbench sees it.
  logic [utf8sd_pkg::CP_W-1:0] pend_payload = '0;
  logic [1:0]                  pend_len = 2'd0;
  logic [1:0]                  pend_cont = 2'd0;

  cp_result_t      expected_cps[$];
  cp_result_t      byte_results[$];
  logic [7:0]      chunk_bytes[$];
  vector_t         directed_vectors[27];

  int unsigned     send_idle_pct = 0;
  int unsigned     recv_idle_pct = 0;
  int unsigned     fail_count = 0;
  int unsigned     cycle_count = 0;

  utf8_stream_decoder_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_text_byte    (in_text_byte),
    .in_end_of_text  (in_end_of_text),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_code_point  (out_code_point),
    .out_is_error    (out_is_error),
    .out_last_of_run (out_last_of_run)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[utf8_stream_decoder_top] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void add_result(input logic [utf8sd_pkg::CP_W-1:0] cp,
                                     input logic err);
    byte_results.push_back('{cp: cp, err: err, last: 1'b0});
  endfunction

  function automatic void drop_sequence();
    pend_payload = '0;
    pend_len = 2'd0;
    pend_cont = 2'd0;
  endfunction

  // Decode a byte with no sequence pending.
  function automatic void decode_fresh(input logic [7:0] b, input logic eot);
    logic is_lead;
    is_lead = 1'b1;
    if (b[7] == 1'b0) begin
      add_result((utf8sd_pkg::CP_W)'(b), 1'b0);
      is_lead = 1'b0;
    end else if (b[7:5] == 3'b110) begin
      pend_len = 2'd1;
      pend_payload = (utf8sd_pkg::CP_W)'(b[4:0]);
    end else if (b[7:4] == 4'b1110) begin
      pend_len = 2'd2;
      pend_payload = (utf8sd_pkg::CP_W)'(b[3:0]);
    end else if (b[7:3] == 5'b11110) begin
      pend_len = 2'd3;
      pend_payload = (utf8sd_pkg::CP_W)'(b[2:0]);
    end else begin
      // Stray continuation or a lead byte of 0xF8 and above.
      add_result(utf8sd_pkg::REPLACEMENT_CP, 1'b1);
      is_lead = 1'b0;
    end
    if (is_lead) begin
      pend_cont = 2'd0;
      // A lead byte that ends the text is one replacement.
      if (eot) begin
        drop_sequence();
        add_result(utf8sd_pkg::REPLACEMENT_CP, 1'b1);
      end
    end
  endfunction

  // Work out the code points that one accepted byte causes.
  function automatic void decode_utf8_byte(input logic [7:0] b, input logic eot);
    int unsigned                 n_err;
    logic [utf8sd_pkg::CP_W-1:0] lowest;
    byte_results.delete();
    if (pend_len == 2'd0) begin
      decode_fresh(b, eot);
    end else if (b[7:6] != 2'b10) begin
      // Broken sequence: one replacement for the lead and each continuation,
      // then the byte starts over.
      n_err = 1 + pend_cont;
      for (int k = 0; k < n_err && k < 3; k++)
        add_result(utf8sd_pkg::REPLACEMENT_CP, 1'b1);
      drop_sequence();
      decode_fresh(b, eot);
    end else begin
      pend_payload = {pend_payload[utf8sd_pkg::CP_W-7:0], b[5:0]};
      pend_cont = pend_cont + 2'd1;
      if (pend_cont >= pend_len) begin
        lowest = (pend_len == 2'd1) ? utf8sd_pkg::MIN_CP_2B :
                 (pend_len == 2'd2) ? utf8sd_pkg::MIN_CP_3B : utf8sd_pkg::MIN_CP_4B;
        // Overlong, out of range or surrogate: one replacement per byte.
        if (pend_payload < lowest || pend_payload > utf8sd_pkg::MAX_CP ||
            (pend_payload >= utf8sd_pkg::SURR_LO &&
             pend_payload <= utf8sd_pkg::SURR_HI)) begin
          for (int k = 0; k <= pend_len; k++)
            add_result(utf8sd_pkg::REPLACEMENT_CP, 1'b1);
        end else begin
          add_result(pend_payload, 1'b0);
        end
        drop_sequence();
      end else if (eot) begin
        drop_sequence();
        add_result(utf8sd_pkg::REPLACEMENT_CP, 1'b1);
      end
    end
    if (eot) drop_sequence();
    if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic vector_t checked_row(input logic [7:0] b, input logic eot,
                                          input logic [2:0] n,
                                          input logic [utf8sd_pkg::CP_W-1:0] cp,
                                          input logic err);
    return '{text_byte: b, eot: eot, fixed_exp: 1'b1, n_results: n, cp: cp, err: err};
  endfunction

  function automatic vector_t predicted_row(input logic [7:0] b);
    return '{text_byte: b, eot: 1'b0, fixed_exp: 1'b0, n_results: 3'd0, cp: '0,
             err: 1'b0};
  endfunction

  // Pick a value in [lo, hi], with extra weight on both ends.
  function automatic logic [utf8sd_pkg::CP_W-1:0] pick_cp(input int unsigned lo,
                                                          input int unsigned hi);
    int unsigned sel;
    sel = $urandom_range(7);
    if (sel == 0) return (utf8sd_pkg::CP_W)'(lo);
    if (sel == 1) return (utf8sd_pkg::CP_W)'(hi);
    return (utf8sd_pkg::CP_W)'($urandom_range(hi, lo));
  endfunction

  // Append the encoding of cp in exactly len bytes, overlong or not.
  function automatic void encode_into(input logic [utf8sd_pkg::CP_W-1:0] cp,
                                      input int unsigned len);
    case (len)
      1: begin
        chunk_bytes.push_back({1'b0, cp[6:0]});
      end
      2: begin
        chunk_bytes.push_back({3'b110, cp[10:6]});
        chunk_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        chunk_bytes.push_back({4'b1110, cp[15:12]});
        chunk_bytes.push_back({2'b10, cp[11:6]});
        chunk_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        chunk_bytes.push_back({5'b11110, cp[20:18]});
        chunk_bytes.push_back({2'b10, cp[17:12]});
        chunk_bytes.push_back({2'b10, cp[11:6]});
        chunk_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic logic [utf8sd_pkg::CP_W-1:0] well_formed_cp(input int unsigned len);
    case (len)
      1:       return pick_cp(32'h0, 32'h7F);
      2:       return pick_cp(32'h80, 32'h7FF);
      3:       return pick_cp(32'h800, 32'hFFFF);
      default: return pick_cp(32'h10000, 32'h10FFFF);
    endcase
  endfunction

  // Build one random chunk of text: mostly one well-formed character.
  function automatic void make_chunk();
    int unsigned     kind;
    int unsigned     len;
    int unsigned     lowest;
    chunk_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 60) begin
      len = $urandom_range(4, 1);
      encode_into(well_formed_cp(len), len);
    end else if (kind < 70) begin
      // Overlong form.
      len = $urandom_range(4, 2);
      lowest = (len == 2) ? 32'h80 : (len == 3) ? 32'h800 : 32'h10000;
      encode_into(pick_cp(0, lowest - 1), len);
    end else if (kind < 76) begin
      // Beyond U+10FFFF.
      encode_into(pick_cp(32'h110000, 32'h1FFFFF), 4);
    end else if (kind < 80) begin
      encode_into(pick_cp(32'hD800, 32'hDFFF), 3);
    end else if (kind < 90) begin
      // Truncated sequence: the next chunk breaks it.
      len = $urandom_range(4, 2);
      encode_into(well_formed_cp(len), len);
      repeat ($urandom_range(len - 1, 1)) void'(chunk_bytes.pop_back());
    end else begin
      repeat ($urandom_range(3, 1)) chunk_bytes.push_back(8'($urandom_range(255)));
    end
  endfunction

  // Offer one byte, wait for the transaction, then record what it must cause.
  task automatic send_item(input vector_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_text_byte <= item.text_byte;
    in_end_of_text <= item.eot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_utf8_byte(item.text_byte, item.eot);
    if (item.fixed_exp) begin
      for (int k = 0; k < item.n_results; k++)
        expected_cps.push_back('{cp: item.cp, err: item.err,
                                 last: (k == item.n_results - 1)});
    end else begin
      foreach (byte_results[k]) expected_cps.push_back(byte_results[k]);
    end
  endtask

  // Random text until the phase has seen enough bytes.
  task automatic send_random_text(input int unsigned n_items);
    int unsigned sent;
    logic        eot;
    sent = 0;
    while (sent < n_items) begin
      make_chunk();
      foreach (chunk_bytes[k]) begin
        eot = ((k == chunk_bytes.size() - 1) && $urandom_range(5) == 0) ||
              ($urandom_range(39) == 0);
        send_item('{text_byte: chunk_bytes[k], eot: eot, fixed_exp: 1'b0,
                    n_results: 3'd0, cp: '0, err: 1'b0});
        sent++;
      end
    end
  endtask

  // Hold the input idle until every expected code point has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_cps.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stalls and the in-order check of each transaction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_output
    cp_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_cps.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected output: cp=%h err=%b last=%b",
                   out_code_point, out_is_error, out_last_of_run);
      end else begin
        want = expected_cps.pop_front();
        if (out_code_point !== want.cp || out_is_error !== want.err ||
            out_last_of_run !== want.last) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("mismatch: expected cp=%h err=%b last=%b, got cp=%h err=%b last=%b",
                     want.cp, want.err, want.last,
                     out_code_point, out_is_error, out_last_of_run);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    directed_vectors = '{
      // ASCII extreme, invalid lead 0xFF, stray continuation.
      checked_row(8'h00, 1'b0, 3'd1, 21'h0, 1'b0),
      checked_row(8'hFF, 1'b0, 3'd1, utf8sd_pkg::REPLACEMENT_CP, 1'b1),
      checked_row(8'h80, 1'b0, 3'd1, utf8sd_pkg::REPLACEMENT_CP, 1'b1),
      // Smallest two-byte character.
      predicted_row(8'hC2), predicted_row(8'h80),
      // Overlong two-byte form.
      predicted_row(8'hC0),
      checked_row(8'hBF, 1'b0, 3'd2, utf8sd_pkg::REPLACEMENT_CP, 1'b1),
      // Surrogate half.
      predicted_row(8'hED), predicted_row(8'hA0),
      checked_row(8'h80, 1'b0, 3'd3, utf8sd_pkg::REPLACEMENT_CP, 1'b1),
      // Just above U+10FFFF.
      predicted_row(8'hF4), predicted_row(8'h90), predicted_row(8'h80),
      checked_row(8'h80, 1'b0, 3'd4, utf8sd_pkg::REPLACEMENT_CP, 1'b1),
      // Largest scalar value.
      predicted_row(8'hF4), predicted_row(8'h8F), predicted_row(8'hBF),
      checked_row(8'hBF, 1'b0, 3'd1, utf8sd_pkg::MAX_CP, 1'b0),
      // A properly encoded U+FFFD is not an error.
      predicted_row(8'hEF), predicted_row(8'hBF), predicted_row(8'hBD),
      // End of text on a continuation that leaves the sequence open.
      predicted_row(8'hE2),
      checked_row(8'h82, 1'b1, 3'd1, utf8sd_pkg::REPLACEMENT_CP, 1'b1),
      // Broken sequence, then a lead byte that ends the text.
      predicted_row(8'hF0), predicted_row(8'h90), predicted_row(8'h80),
      checked_row(8'hF0, 1'b1, 3'd4, utf8sd_pkg::REPLACEMENT_CP, 1'b1)
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase 1: sender idles lightly, receiver stalls about half the time.
    send_idle_pct = 18;
    recv_idle_pct = 49;
    foreach (directed_vectors[i]) send_item(directed_vectors[i]);
    send_random_text(PHASE_ITEMS);
    drain_results();

    // Phase 2: the other way round.
    send_idle_pct = 49;
    recv_idle_pct = 18;
    send_random_text(PHASE_ITEMS);
    drain_results();

    // Phase 3: full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_text(PHASE_ITEMS);
    drain_results();

    // Watch for stray outputs a little longer.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("[utf8_stream_decoder_top] OK");
    end else begin
      $display("[utf8_stream_decoder_top] ERROR");
    end
    $finish;
  end

endmodule
